/* rtl/core/detection_box_decode_defines.svh */
`ifndef DETECTION_BOX_DECODE_DEFINES_SVH
`define DETECTION_BOX_DECODE_DEFINES_SVH

// same-cycle implication, checked from reset release on
`define DBD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("detection_box_decode: same-cycle check failed");

// next-cycle implication
`define DBD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("detection_box_decode: next-cycle check failed");

`endif

/* rtl/core/dbd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dbd_pkg;

    localparam int NUM_CLASSES_DEF = 80;
    localparam int NUM_ANCHORS_DEF = 3;
    localparam int NUM_HEADS_DEF   = 3;

    localparam int IN_W   = 88;
    localparam int OUT_W  = 88;
    localparam int DIV_W  = 31;
    localparam int CNT_W  = 5;

    localparam logic [2:0] CFG_THRESHOLD  = 3'd0;
    localparam logic [2:0] CFG_BOX_SCALE  = 3'd1;
    localparam logic [2:0] CFG_OBJ_SCALE  = 3'd2;
    localparam logic [2:0] CFG_NET_WIDTH  = 3'd3;
    localparam logic [2:0] CFG_NET_HEIGHT = 3'd4;

    localparam logic [8:0] ANCHOR_W [3][3] = '{
        '{9'd10,  9'd16,  9'd33},
        '{9'd30,  9'd62,  9'd59},
        '{9'd116, 9'd156, 9'd373}
    };
    localparam logic [8:0] ANCHOR_H [3][3] = '{
        '{9'd13,  9'd30,  9'd23},
        '{9'd61,  9'd45,  9'd119},
        '{9'd90,  9'd198, 9'd326}
    };

    typedef enum logic [4:0] {
        ST_IDLE, ST_OBJ, ST_CHK, ST_SIGX, ST_SIGY, ST_SIGW, ST_SIGH,
        ST_DROW, ST_DROWW, ST_NUMX, ST_DIVX, ST_DIVXW, ST_NUMY, ST_DIVY,
        ST_DIVYW, ST_SQW, ST_SQH, ST_HALFW, ST_HALFH, ST_CORN
    } state_t;

    typedef enum logic [1:0] {
        DIM_X, DIM_Y, DIM_W, DIM_H
    } dim_sel_t;

    typedef struct packed {
        logic     accept;
        logic     obj_mul;
        logic     conf_en;
        logic     sig_en;
        logic     num_en;
        logic     div_start;
        logic     div_store;
        logic     div_row;
        logic     sq_en;
        logic     half_en;
        logic     corn_load;
        dim_sel_t sel;
    } cmd_t;

    typedef struct packed {
        logic drop;
        logic div_done;
        logic div_busy;
        logic out_free;
    } status_t;

    // piecewise-linear sigmoid, Q.16 in, 0..65536 out
    function automatic logic [16:0] sig_q16(input logic signed [23:0] v);
        logic [23:0] a;
        logic [16:0] y;
        a = v[23] ? 24'(-v) : 24'(v);
        if (a >= 24'd327680)
            y = 17'd65536;
        else if (a >= 24'd155648)
            y = 17'(a >> 5) + 17'd55296;
        else if (a >= 24'd65536)
            y = 17'(a >> 3) + 17'd40960;
        else
            y = 17'(a >> 2) + 17'd32768;
        return v[23] ? 17'(17'd65536 - y) : y;
    endfunction

    function automatic logic [15:0] sat16(input logic signed [33:0] v);
        if (v > 34'sd32767)
            return 16'h7FFF;
        else if (v < -34'sd32768)
            return 16'h8000;
        else
            return v[15:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/dbd_div.sv */
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle
module dbd_div (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [dbd_pkg::DIV_W-1:0] dividend,
    input  wire logic [7:0]              divisor,
    output logic [dbd_pkg::DIV_W-1:0]    quot,
    output logic [7:0]                   rem,
    output logic                         busy,
    output logic                         done
);

    logic [dbd_pkg::DIV_W-1:0] quot_reg, quot_next;
    logic [7:0]                rem_reg, rem_next;
    logic [7:0]                div_reg;
    logic [dbd_pkg::CNT_W-1:0] cnt_reg;
    logic                      busy_reg, done_reg;
    logic [8:0]                trial;
    logic [8:0]                diff;

    always_comb
    begin
        trial = {rem_reg, quot_reg[dbd_pkg::DIV_W-1]};
        diff  = trial - {1'b0, div_reg};
        if (trial >= {1'b0, div_reg})
        begin
            rem_next  = diff[7:0];
            quot_next = {quot_reg[dbd_pkg::DIV_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = trial[7:0];
            quot_next = {quot_reg[dbd_pkg::DIV_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= dbd_pkg::CNT_W'(dbd_pkg::DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == dbd_pkg::CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign quot = quot_reg;
    assign rem  = rem_reg;
    assign busy = busy_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

/* rtl/core/dbd_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module dbd_datapath #(
    parameter int NUM_CLASSES = dbd_pkg::NUM_CLASSES_DEF,
    parameter int NUM_ANCHORS = dbd_pkg::NUM_ANCHORS_DEF,
    parameter int NUM_HEADS   = dbd_pkg::NUM_HEADS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire dbd_pkg::cmd_t            cmd,
    output dbd_pkg::status_t              status,
    input  wire logic [dbd_pkg::IN_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [dbd_pkg::OUT_W-1:0]     m_tdata,
    input  wire logic                     cfg_we,
    input  wire logic [2:0]               cfg_addr,
    input  wire logic [15:0]              cfg_wdata
);

    localparam int HMAX_I = (NUM_HEADS - 1 > 2) ? 2 : NUM_HEADS - 1;
    localparam int AMAX_I = (NUM_ANCHORS - 1 > 2) ? 2 : NUM_ANCHORS - 1;
    localparam logic [1:0] HEAD_MAX = 2'(HMAX_I);
    localparam logic [1:0] ANC_MAX  = 2'(AMAX_I);
    localparam logic [6:0] CLS_LAST = 7'(NUM_CLASSES - 1);

    // configuration
    logic signed [15:0] thr_reg;
    logic [15:0]        box_scale_reg, obj_scale_reg;
    logic [11:0]        net_w_reg, net_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= '0;
            box_scale_reg <= 16'd4096;
            obj_scale_reg <= 16'd4096;
            net_w_reg     <= 12'd640;
            net_h_reg     <= 12'd640;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                dbd_pkg::CFG_THRESHOLD:  thr_reg       <= cfg_wdata;
                dbd_pkg::CFG_BOX_SCALE:  box_scale_reg <= cfg_wdata;
                dbd_pkg::CFG_OBJ_SCALE:  obj_scale_reg <= cfg_wdata;
                dbd_pkg::CFG_NET_WIDTH:  net_w_reg     <= cfg_wdata[11:0];
                dbd_pkg::CFG_NET_HEIGHT: net_h_reg     <= cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    // input unpack
    logic [1:0]        in_head, in_anchor;
    logic [13:0]       in_gidx;
    logic [7:0]        in_gw, in_gh;
    logic signed [7:0] in_score;

    assign in_head   = s_tdata[1:0];
    assign in_anchor = s_tdata[3:2];
    assign in_gidx   = s_tdata[17:4];
    assign in_gw     = s_tdata[25:18];
    assign in_gh     = s_tdata[33:26];
    assign in_score  = s_tdata[81:74];

    // running argmax
    logic signed [7:0] best_score_reg;
    logic [6:0]        best_class_reg, class_cnt_reg, cls_reg;
    logic              class_full_reg;
    logic              better;
    logic [6:0]        best_class_next;

    assign better          = !class_full_reg && (in_score > best_score_reg);
    assign best_class_next = better ? class_cnt_reg : best_class_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_score_reg <= -8'sd128;
            best_class_reg <= '0;
            class_cnt_reg  <= '0;
            class_full_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            if (better)
            begin
                best_score_reg <= in_score;
                best_class_reg <= class_cnt_reg;
            end
            if (!class_full_reg)
            begin
                if (class_cnt_reg >= CLS_LAST)
                    class_full_reg <= 1'b1;
                else
                    class_cnt_reg <= class_cnt_reg + 1'b1;
            end
        end
        else if (cmd.obj_mul)
        begin
            best_score_reg <= -8'sd128;
            best_class_reg <= '0;
            class_cnt_reg  <= '0;
            class_full_reg <= 1'b0;
        end
    end

    // candidate payload, captured on every item; the last one is what counts
    logic [1:0]        head_reg, anc_reg;
    logic [13:0]       gidx_reg;
    logic [7:0]        gw_reg, gh_reg;
    logic signed [7:0] rx_reg, ry_reg, rw_reg, rh_reg, robj_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            head_reg <= (in_head > HEAD_MAX) ? HEAD_MAX : in_head;
            anc_reg  <= (in_anchor > ANC_MAX) ? ANC_MAX : in_anchor;
            gidx_reg <= in_gidx;
            gw_reg   <= (in_gw == 8'd0) ? 8'd1 : in_gw;
            gh_reg   <= (in_gh == 8'd0) ? 8'd1 : in_gh;
            rx_reg   <= s_tdata[41:34];
            ry_reg   <= s_tdata[49:42];
            rw_reg   <= s_tdata[57:50];
            rh_reg   <= s_tdata[65:58];
            robj_reg <= s_tdata[73:66];
            cls_reg  <= best_class_next;
        end
    end

    // objectness and confidence
    logic signed [23:0] obj_reg;
    logic signed [24:0] obj_prod;
    logic [15:0]        conf_reg;
    logic [16:0]        conf_sig;

    assign obj_prod = 25'(robj_reg) * 25'($signed({1'b0, obj_scale_reg}));
    assign conf_sig = dbd_pkg::sig_q16(obj_reg);
    assign status.drop = obj_reg < $signed({thr_reg, 8'd0});

    always_ff @(posedge clk)
    begin
        if (cmd.obj_mul)
            obj_reg <= obj_prod[23:0];
        if (cmd.conf_en)
            conf_reg <= conf_sig[16] ? 16'hFFFF : conf_sig[15:0];
    end

    // box sigmoids, one per cycle
    logic signed [7:0]  raw_sel;
    logic signed [24:0] box_prod;
    logic [16:0]        box_sig;
    logic [16:0]        sx_reg, sy_reg, sw_reg, sh_reg;

    always_comb
    begin
        unique case (cmd.sel)
            dbd_pkg::DIM_X: raw_sel = rx_reg;
            dbd_pkg::DIM_Y: raw_sel = ry_reg;
            dbd_pkg::DIM_W: raw_sel = rw_reg;
            dbd_pkg::DIM_H: raw_sel = rh_reg;
            default:        raw_sel = rx_reg;
        endcase
    end

    assign box_prod = 25'(raw_sel) * 25'($signed({1'b0, box_scale_reg}));
    assign box_sig  = dbd_pkg::sig_q16(box_prod[23:0]);

    always_ff @(posedge clk)
    begin
        if (cmd.sig_en)
        begin
            unique case (cmd.sel)
                dbd_pkg::DIM_X: sx_reg <= box_sig;
                dbd_pkg::DIM_Y: sy_reg <= box_sig;
                dbd_pkg::DIM_W: sw_reg <= box_sig;
                dbd_pkg::DIM_H: sh_reg <= box_sig;
                default: ;
            endcase
        end
    end

    // centre numerator times net size, floor /4096 by arithmetic shift
    logic [13:0]        row_reg;
    logic [7:0]         col_reg;
    logic signed [32:0] num;
    logic [11:0]        net_sel;
    logic signed [45:0] num_prod;
    logic signed [31:0] mx_reg, my_reg;

    always_comb
    begin
        if (cmd.sel == dbd_pkg::DIM_Y)
        begin
            num     = $signed({15'd0, sy_reg, 1'b0}) + $signed({3'd0, row_reg, 16'd0})
                      - 33'sd32768;
            net_sel = net_h_reg;
        end
        else
        begin
            num     = $signed({15'd0, sx_reg, 1'b0}) + $signed({9'd0, col_reg, 16'd0})
                      - 33'sd32768;
            net_sel = net_w_reg;
        end
    end

    assign num_prod = 46'(num) * 46'($signed({1'b0, net_sel}));

    always_ff @(posedge clk)
    begin
        if (cmd.num_en)
        begin
            if (cmd.sel == dbd_pkg::DIM_Y)
                my_reg <= num_prod[43:12];
            else
                mx_reg <= num_prod[43:12];
        end
    end

    // shared divider: row/column, then floor division of each centre by grid size
    logic                      m_neg;
    logic signed [31:0]        m_sel;
    logic [31:0]               m_abs;
    logic [dbd_pkg::DIV_W-1:0] div_dividend, div_quot;
    logic [7:0]                div_divisor, div_rem;
    logic                      div_busy, div_done;
    logic signed [31:0]        div_res;
    logic signed [31:0]        cx_reg, cy_reg;

    assign m_sel = (cmd.sel == dbd_pkg::DIM_Y) ? my_reg : mx_reg;
    assign m_neg = m_sel[31];
    assign m_abs = m_neg ? 32'(-m_sel) : 32'(m_sel);

    assign div_dividend = cmd.div_row ? dbd_pkg::DIV_W'(gidx_reg) : m_abs[dbd_pkg::DIV_W-1:0];
    assign div_divisor  = (cmd.div_row || cmd.sel != dbd_pkg::DIM_Y) ? gw_reg : gh_reg;

    dbd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quot     (div_quot),
        .rem      (div_rem),
        .busy     (div_busy),
        .done     (div_done)
    );

    // negative values round towards minus infinity
    assign div_res = m_neg ? -$signed({1'b0, div_quot}) - $signed({31'd0, div_rem != 8'd0})
                           : $signed({1'b0, div_quot});

    always_ff @(posedge clk)
    begin
        if (cmd.div_store)
        begin
            if (cmd.div_row)
            begin
                row_reg <= div_quot[13:0];
                col_reg <= div_rem;
            end
            else if (cmd.sel == dbd_pkg::DIM_Y)
                cy_reg <= div_res;
            else
                cx_reg <= div_res;
        end
    end

    assign status.div_busy = div_busy;
    assign status.div_done = div_done;

    // sizes: q = (2s)^2 >> 16, half = (q * anchor) >> 13
    logic [17:0] s2;
    logic [35:0] sq_prod;
    logic [18:0] qw_reg, qh_reg;
    logic [18:0] q_sel;
    logic [8:0]  anc_dim;
    logic [27:0] half_prod;
    logic [14:0] hw_reg, hh_reg;

    assign s2      = (cmd.sel == dbd_pkg::DIM_H) ? {sh_reg, 1'b0} : {sw_reg, 1'b0};
    assign sq_prod = 36'(s2) * 36'(s2);
    assign q_sel   = (cmd.sel == dbd_pkg::DIM_H) ? qh_reg : qw_reg;
    assign anc_dim = (cmd.sel == dbd_pkg::DIM_H) ? dbd_pkg::ANCHOR_H[head_reg][anc_reg]
                                                 : dbd_pkg::ANCHOR_W[head_reg][anc_reg];
    assign half_prod = 28'(q_sel) * 28'(anc_dim);

    always_ff @(posedge clk)
    begin
        if (cmd.sq_en)
        begin
            if (cmd.sel == dbd_pkg::DIM_H)
                qh_reg <= sq_prod[34:16];
            else
                qw_reg <= sq_prod[34:16];
        end
        if (cmd.half_en)
        begin
            if (cmd.sel == dbd_pkg::DIM_H)
                hh_reg <= half_prod[27:13];
            else
                hw_reg <= half_prod[27:13];
        end
    end

    // output register
    logic signed [33:0] cx_ext, cy_ext, hw_ext, hh_ext;
    logic               out_valid_reg;
    logic [dbd_pkg::OUT_W-1:0] out_reg;

    assign cx_ext = {{2{cx_reg[31]}}, cx_reg};
    assign cy_ext = {{2{cy_reg[31]}}, cy_reg};
    assign hw_ext = $signed({19'd0, hw_reg});
    assign hh_ext = $signed({19'd0, hh_reg});

    assign status.out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.corn_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.corn_load)
        begin
            out_reg <= {1'b0,
                        dbd_pkg::sat16(cy_ext + hh_ext),
                        dbd_pkg::sat16(cx_ext + hw_ext),
                        dbd_pkg::sat16(cy_ext - hh_ext),
                        dbd_pkg::sat16(cx_ext - hw_ext),
                        conf_reg,
                        cls_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

`default_nettype wire

/* rtl/core/dbd_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module dbd_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    input  wire logic             s_tlast,
    output logic                  s_tready,
    input  wire dbd_pkg::status_t status,
    output dbd_pkg::cmd_t         cmd
);

    dbd_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= dbd_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.sel    = dbd_pkg::DIM_X;
        s_tready   = 1'b0;
        unique case (state_reg)
            dbd_pkg::ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && s_tlast)
                    state_next = dbd_pkg::ST_OBJ;
            end
            dbd_pkg::ST_OBJ:
            begin
                cmd.obj_mul = 1'b1;
                state_next  = dbd_pkg::ST_CHK;
            end
            dbd_pkg::ST_CHK:
            begin
                if (status.drop)
                    state_next = dbd_pkg::ST_IDLE;
                else
                begin
                    cmd.conf_en = 1'b1;
                    state_next  = dbd_pkg::ST_SIGX;
                end
            end
            dbd_pkg::ST_SIGX:
            begin
                cmd.sig_en = 1'b1;
                state_next = dbd_pkg::ST_SIGY;
            end
            dbd_pkg::ST_SIGY:
            begin
                cmd.sig_en = 1'b1;
                cmd.sel    = dbd_pkg::DIM_Y;
                state_next = dbd_pkg::ST_SIGW;
            end
            dbd_pkg::ST_SIGW:
            begin
                cmd.sig_en = 1'b1;
                cmd.sel    = dbd_pkg::DIM_W;
                state_next = dbd_pkg::ST_SIGH;
            end
            dbd_pkg::ST_SIGH:
            begin
                cmd.sig_en = 1'b1;
                cmd.sel    = dbd_pkg::DIM_H;
                state_next = dbd_pkg::ST_DROW;
            end
            dbd_pkg::ST_DROW:
            begin
                cmd.div_row   = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = dbd_pkg::ST_DROWW;
            end
            dbd_pkg::ST_DROWW:
            begin
                cmd.div_row = 1'b1;
                if (status.div_done)
                begin
                    cmd.div_store = 1'b1;
                    state_next    = dbd_pkg::ST_NUMX;
                end
            end
            dbd_pkg::ST_NUMX:
            begin
                cmd.num_en = 1'b1;
                state_next = dbd_pkg::ST_DIVX;
            end
            dbd_pkg::ST_DIVX:
            begin
                cmd.div_start = 1'b1;
                state_next    = dbd_pkg::ST_DIVXW;
            end
            dbd_pkg::ST_DIVXW:
            begin
                if (status.div_done)
                begin
                    cmd.div_store = 1'b1;
                    state_next    = dbd_pkg::ST_NUMY;
                end
            end
            dbd_pkg::ST_NUMY:
            begin
                cmd.num_en = 1'b1;
                cmd.sel    = dbd_pkg::DIM_Y;
                state_next = dbd_pkg::ST_DIVY;
            end
            dbd_pkg::ST_DIVY:
            begin
                cmd.div_start = 1'b1;
                cmd.sel       = dbd_pkg::DIM_Y;
                state_next    = dbd_pkg::ST_DIVYW;
            end
            dbd_pkg::ST_DIVYW:
            begin
                cmd.sel = dbd_pkg::DIM_Y;
                if (status.div_done)
                begin
                    cmd.div_store = 1'b1;
                    state_next    = dbd_pkg::ST_SQW;
                end
            end
            dbd_pkg::ST_SQW:
            begin
                cmd.sq_en  = 1'b1;
                cmd.sel    = dbd_pkg::DIM_W;
                state_next = dbd_pkg::ST_SQH;
            end
            dbd_pkg::ST_SQH:
            begin
                cmd.sq_en  = 1'b1;
                cmd.sel    = dbd_pkg::DIM_H;
                state_next = dbd_pkg::ST_HALFW;
            end
            dbd_pkg::ST_HALFW:
            begin
                cmd.half_en = 1'b1;
                cmd.sel     = dbd_pkg::DIM_W;
                state_next  = dbd_pkg::ST_HALFH;
            end
            dbd_pkg::ST_HALFH:
            begin
                cmd.half_en = 1'b1;
                cmd.sel     = dbd_pkg::DIM_H;
                state_next  = dbd_pkg::ST_CORN;
            end
            dbd_pkg::ST_CORN:
            begin
                if (status.out_free)
                begin
                    cmd.corn_load = 1'b1;
                    state_next    = dbd_pkg::ST_IDLE;
                end
            end
            default:
                state_next = dbd_pkg::ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/detection_box_decode.sv */
// channel  | dir | handshake           | payload
// s_*      | in  | s_tvalid / s_tready | s_tdata (88 b), s_tlast = last_class
// m_*      | out | m_tvalid / m_tready | m_tdata (88 b)
// cfg_*    | in  | cfg_we              | cfg_addr (3 b), cfg_wdata (16 b)
//
// Class items that are not last are taken one per cycle.
// A last item holds s_tready low, when the candidate passes, until it has made three passes
// of the shared bit-serial divider and its result is loaded into the free output register;
// a dropped candidate releases it after the threshold check.
// The result sits in an output register; further class items are taken while it waits,
// but the next passing candidate holds in its final state until that register drains.
// rst_n clears the controller, argmax state and output valid, and resets the configuration registers to defaults.
`timescale 1ns / 1ps
`default_nettype none

`include "detection_box_decode_defines.svh"

module detection_box_decode #(
    parameter int NUM_CLASSES = dbd_pkg::NUM_CLASSES_DEF,
    parameter int NUM_ANCHORS = dbd_pkg::NUM_ANCHORS_DEF,
    parameter int NUM_HEADS   = dbd_pkg::NUM_HEADS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // head, anchor, grid_index, grid_width, grid_height, raw_x, raw_y, raw_w,
    // raw_h, raw_obj, class_score, zero pad
    input  wire logic [dbd_pkg::IN_W-1:0] s_tdata,
    input  wire logic                     s_tlast,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // class_index, confidence, x_min, y_min, x_max, y_max, zero pad
    output logic [dbd_pkg::OUT_W-1:0]     m_tdata,
    input  wire logic                     cfg_we,
    input  wire logic [2:0]               cfg_addr,
    input  wire logic [15:0]              cfg_wdata
);

    dbd_pkg::cmd_t    cmd;
    dbd_pkg::status_t status;

    dbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dbd_datapath #(
        .NUM_CLASSES (NUM_CLASSES),
        .NUM_ANCHORS (NUM_ANCHORS),
        .NUM_HEADS   (NUM_HEADS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    `DBD_ASSERT_NXT(a_mid_run_no_stall, s_tvalid && s_tready && !s_tlast, s_tready)
    `DBD_ASSERT_NXT(a_last_busy, s_tvalid && s_tready && s_tlast, !s_tready)
    `DBD_ASSERT_IMP(a_div_idle_on_input, s_tready, !status.div_busy)

endmodule

`default_nettype wire
